@@ design/srtf_pkg.sv @@
package srtf_pkg;

   localparam int MAX_PROCS_DEFAULT = 16;
   localparam int TIME_BITS_DEFAULT = 16;
   localparam int CLOCK_BITS = 21;
   localparam int NUMBER_BITS = 5;
   localparam int SPAN_BITS = 20;

   // Control from the sequencer to the scan unit.
   typedef struct packed {
      logic scan_start;
      logic sort_mode;
   } scan_ctrl_type;

endpackage

@@ design/srtf_completion_scheduler_unit.sv @@
// Channel   Ports                       Handshake
// input     req_*                       start high and busy low
// result    rsp_*                       rsp_valid for one cycle
//
// Loading accepts one word per cycle. After the last word an insertion sort
// does one compare or adjacent swap per cycle. Each scheduling event then
// scans for the ready minimum, scans for the next arrival through the
// compare unit, and updates the clock and the remaining times.
// Results stream out one per cycle.
// Reset is synchronous and clears the state, counters, clock and rsp_valid. The receiver cannot stall.
module srtf_completion_scheduler_unit #(
   parameter int MAX_PROCS = srtf_pkg::MAX_PROCS_DEFAULT,
   parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [15:0]                        req_arrival_time,
   input  logic [15:0]                        req_burst_time,
   input  logic                               req_last_process,
   output logic                               rsp_valid,
   output logic [srtf_pkg::NUMBER_BITS-1:0]   rsp_process_number,
   output logic [15:0]                        rsp_arrival_out,
   output logic [15:0]                        rsp_burst_out,
   output logic [srtf_pkg::CLOCK_BITS-1:0]    rsp_completion_time,
   output logic [srtf_pkg::SPAN_BITS-1:0]     rsp_turnaround_time,
   output logic [srtf_pkg::SPAN_BITS-1:0]     rsp_waiting_time,
   output logic                               rsp_overflowed,
   output logic                               rsp_last_result
);
   import srtf_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_PROCS);
   localparam int CNT_BITS = $clog2(MAX_PROCS + 1);
   localparam int CLK_BITS = TIME_BITS + CNT_BITS + 1;

   localparam logic [2:0] ST_LOAD   = 3'd0;
   localparam logic [2:0] ST_SORT   = 3'd1;
   localparam logic [2:0] ST_PICK   = 3'd2;
   localparam logic [2:0] ST_NEXT   = 3'd3;
   localparam logic [2:0] ST_UPDATE = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   logic [TIME_BITS-1:0]  arr_mem [MAX_PROCS];
   logic [TIME_BITS-1:0]  bur_mem [MAX_PROCS];
   logic [TIME_BITS-1:0]  rem_mem [MAX_PROCS];
   logic [IDX_BITS-1:0]   num_mem [MAX_PROCS];
   logic [CLK_BITS-1:0]   fin_mem [MAX_PROCS];

   logic [2:0]            state_ff;
   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   left_ff;
   logic                  over_ff;
   logic [CLK_BITS-1:0]   clock_ff;
   logic [CNT_BITS-1:0]   i_ff;
   logic [CNT_BITS-1:0]   j_ff;
   logic [IDX_BITS-1:0]   pick_ff;
   logic [TIME_BITS-1:0]  pick_rem_ff;
   logic                  pick_ok_ff;
   logic [TIME_BITS-1:0]  next_ff;
   logic                  next_ok_ff;

   logic [IDX_BITS-1:0]   jx;
   logic [IDX_BITS-1:0]   jm;
   logic                  accept;
   logic                  in_room;
   logic [TIME_BITS-1:0]  in_arr, in_bur;
   scan_ctrl_type         ctrl;
   logic                  scan_ready, scan_future, scan_found;
   logic [TIME_BITS-1:0]  scan_best;
   logic [CLK_BITS-1:0]   end_time;
   logic [CLK_BITS-1:0]   next_wide;
   logic [CLK_BITS-1:0]   tat;
   logic [CLK_BITS-1:0]   wt;

   assign busy    = (state_ff != ST_LOAD);
   assign accept  = start && !busy;
   assign in_room = (count_ff < CNT_BITS'(MAX_PROCS));
   assign in_arr  = TIME_BITS'(req_arrival_time);
   assign in_bur  = TIME_BITS'(req_burst_time);
   assign jx      = j_ff[IDX_BITS-1:0];
   assign jm      = IDX_BITS'(j_ff - 1'b1);

   // Compare unit: scans one stored entry per cycle for the next arrival.
   assign ctrl.scan_start = ((state_ff == ST_SORT) && (j_ff == 0 || i_ff == count_ff))
                            || (state_ff == ST_UPDATE);
   assign ctrl.sort_mode  = (state_ff == ST_NEXT);
   assign scan_ready  = ({{(CLK_BITS-TIME_BITS){1'b0}}, arr_mem[jx]} <= clock_ff)
                        && (rem_mem[jx] != '0);
   assign scan_future = ({{(CLK_BITS-TIME_BITS){1'b0}}, arr_mem[jx]} > clock_ff);

   srtf_scan_unit #(.TIME_BITS(TIME_BITS)) u_scan (
      .clock       (clock),
      .reset       (reset),
      .clear       (ctrl.scan_start),
      .step        ((state_ff == ST_NEXT) && j_ff < count_ff),
      .sort_mode   (ctrl.sort_mode),
      .ready_in    (scan_ready),
      .future_in   (scan_future),
      .remaining_in(rem_mem[jx]),
      .arrival_in  (arr_mem[jx]),
      .found       (scan_found),
      .best_value  (scan_best)
   );

   assign end_time  = clock_ff + CLK_BITS'(pick_rem_ff);
   assign next_wide = CLK_BITS'(next_ff);
   assign tat = fin_mem[jx] - CLK_BITS'(arr_mem[jx]);
   assign wt  = tat - CLK_BITS'(bur_mem[jx]);

   // Sequencer: load, insertion sort, scheduling events, emit.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         over_ff  <= 1'b0;
         clock_ff <= '0;
         left_ff  <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  if (in_room) begin
                     arr_mem[count_ff[IDX_BITS-1:0]] <= in_arr;
                     bur_mem[count_ff[IDX_BITS-1:0]] <= in_bur;
                     rem_mem[count_ff[IDX_BITS-1:0]] <= in_bur;
                     num_mem[count_ff[IDX_BITS-1:0]] <= count_ff[IDX_BITS-1:0];
                     fin_mem[count_ff[IDX_BITS-1:0]] <= CLK_BITS'(in_arr);
                     count_ff <= count_ff + 1'b1;
                     if (in_bur != '0) left_ff <= left_ff + 1'b1;
                  end else begin
                     over_ff <= 1'b1;
                  end
                  if (req_last_process) begin
                     state_ff <= ST_SORT;
                     i_ff     <= CNT_BITS'(1);
                     j_ff     <= CNT_BITS'(1);
                  end
               end
            end
            ST_SORT: begin
               // One swap of adjacent entries per cycle.
               if (i_ff >= count_ff) begin
                  state_ff <= ST_PICK;
                  j_ff     <= '0;
                  clock_ff <= '0;
               end else if (j_ff != 0 && arr_mem[jm] > arr_mem[jx]) begin
                  arr_mem[jm] <= arr_mem[jx];  arr_mem[jx] <= arr_mem[jm];
                  bur_mem[jm] <= bur_mem[jx];  bur_mem[jx] <= bur_mem[jm];
                  rem_mem[jm] <= rem_mem[jx];  rem_mem[jx] <= rem_mem[jm];
                  num_mem[jm] <= num_mem[jx];  num_mem[jx] <= num_mem[jm];
                  fin_mem[jm] <= fin_mem[jx];  fin_mem[jx] <= fin_mem[jm];
                  j_ff <= j_ff - 1'b1;
               end else begin
                  i_ff <= i_ff + 1'b1;
                  j_ff <= i_ff + 1'b1;
               end
            end
            ST_PICK: begin
               // Ready minimum, earliest entry wins ties.
               if (left_ff == 0) begin
                  state_ff <= ST_EMIT;
                  j_ff     <= '0;
               end else if (j_ff < count_ff) begin
                  if (scan_ready && (!pick_ok_ff || rem_mem[jx] < pick_rem_ff)) begin
                     pick_ff     <= jx;
                     pick_rem_ff <= rem_mem[jx];
                     pick_ok_ff  <= 1'b1;
                  end
                  j_ff <= j_ff + 1'b1;
               end else begin
                  state_ff <= ST_NEXT;
                  j_ff     <= '0;
               end
            end
            ST_NEXT: begin
               if (j_ff < count_ff) begin
                  j_ff <= j_ff + 1'b1;
               end else begin
                  next_ff    <= scan_best;
                  next_ok_ff <= scan_found;
                  state_ff   <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               if (!pick_ok_ff) begin
                  if (next_ok_ff) clock_ff <= next_wide;
                  else left_ff <= '0;
               end else if (next_ok_ff && end_time > next_wide) begin
                  rem_mem[pick_ff] <= pick_rem_ff - TIME_BITS'(next_wide - clock_ff);
                  clock_ff <= next_wide;
               end else begin
                  clock_ff <= end_time;
                  rem_mem[pick_ff] <= '0;
                  fin_mem[pick_ff] <= end_time;
                  left_ff <= left_ff - 1'b1;
               end
               pick_ok_ff <= 1'b0;
               j_ff       <= '0;
               state_ff   <= ST_PICK;
            end
            ST_EMIT: begin
               if (j_ff + 1'b1 >= count_ff) begin
                  state_ff <= ST_LOAD;
                  count_ff <= '0;
                  over_ff  <= 1'b0;
                  left_ff  <= '0;
                  clock_ff <= '0;
               end
               j_ff <= j_ff + 1'b1;
            end
            default: state_ff <= ST_LOAD;
         endcase
         if (state_ff == ST_LOAD) pick_ok_ff <= 1'b0;
      end
   end

   // Result word, one per cycle during the emit phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == ST_EMIT) && (j_ff < count_ff);
      end
      rsp_process_number  <= NUMBER_BITS'({1'b0, num_mem[jx]} + 1'b1);
      rsp_arrival_out     <= 16'(arr_mem[jx]);
      rsp_burst_out       <= 16'(bur_mem[jx]);
      rsp_completion_time <= CLOCK_BITS'(fin_mem[jx]);
      rsp_turnaround_time <= SPAN_BITS'(tat);
      rsp_waiting_time    <= SPAN_BITS'(wt);
      rsp_overflowed      <= over_ff;
      rsp_last_result     <= (j_ff + 1'b1 == count_ff);
   end
endmodule

@@ design/srtf_scan_unit.sv @@
module srtf_scan_unit #(
   parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           clear,
   input  logic                           step,
   input  logic                           sort_mode,
   input  logic                           ready_in,
   input  logic                           future_in,
   input  logic [TIME_BITS-1:0]           remaining_in,
   input  logic [TIME_BITS-1:0]           arrival_in,
   output logic                           found,
   output logic [TIME_BITS-1:0]           best_value
);
   import srtf_pkg::*;

   logic                 found_ff, found_in;
   logic [TIME_BITS-1:0] best_ff, best_in;

   // One compare per cycle keeps the running minimum or first future arrival.
   always_comb begin
      found_in = found_ff;
      best_in  = best_ff;
      if (clear) begin
         found_in = 1'b0;
      end else if (step) begin
         if (sort_mode) begin
            if (future_in && !found_ff) begin
               found_in = 1'b1;
               best_in  = arrival_in;
            end
         end else if (ready_in && (!found_ff || remaining_in < best_ff)) begin
            found_in = 1'b1;
            best_in  = remaining_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      best_ff <= best_in;
   end

   assign found      = found_ff;
   assign best_value = best_ff;
endmodule
